>>> hw/rtl/pca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller package
// Shared widths, register indexes, constants and structs for the PI
// controller with integral clamp anti-windup.
// ----------------------------------------------------------------------------
package pca_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 31;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_GAIN = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_RESET_TIME = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_OUTPUT = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_INTERVAL = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [15:0] GAIN_RST = 16'd256;
	localparam logic [23:0] RESET_TIME_RST = 24'd1000;
	localparam logic [30:0] MAX_OUTPUT_RST = 31'd6553600;
	localparam logic [15:0] INTERVAL_RST = 16'd1000;

	// Saturation value of 31-bit Q15.16 quantities.
	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
	// Cap on the inner term before the gain multiply (2^40).
	localparam logic [48:0] INNER_CAP = 49'h100_0000_0000;

	typedef struct packed {
		logic [15:0] gain_q8_8;
		logic [23:0] reset_time_ms;
		logic [30:0] max_output;
		logic [15:0] interval_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] error_in;
		logic               reset_pulse;
		logic               freeze_req;
		logic               inhibit_req;
		logic               inputs_valid;
	} item_t;

	typedef struct packed {
		logic [30:0] drive_out;
		logic [30:0] integral_sum;
		logic        inhibited;
	} result_t;

endpackage

>>> hw/rtl/pca_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller shared multiplier
// Unsigned 32 x 32 multiplier with a registered 64-bit product, shared by
// every multiply step of the sequencer.
// ----------------------------------------------------------------------------
module pca_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);

	// Product is registered so that the next step starts from a clean register.
	always_ff @(posedge clk) begin
		p_q <= {32'b0, a} * {32'b0, b};
	end

endmodule

>>> hw/rtl/pca_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller iterative divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per
// cycle. Done pulses for one cycle after the last step.
// ----------------------------------------------------------------------------
module pca_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done_q,
	output logic [63:0] quot
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] nq_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic [33:0] diff;
	logic        ge;

	// One trial subtraction per cycle.
	assign trial = {rem_q, nq_q[63]};
	assign diff = {1'b0, trial} - {2'b0, den_q};
	assign ge = ~diff[33];
	assign quot = nq_q;

	// Step counter and handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			nq_q <= {nq_q[62:0], ge};
		end
	end

endmodule

>>> hw/rtl/pca_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller core
// Sequencer and datapath: holds the controller state and steps one request
// through the shared multiplier and the iterative divider.
// ----------------------------------------------------------------------------
module pca_core import pca_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	input  item_t   item,
	output logic    ready,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0_0000_0000_0001,
		S_LIM_A  = 13'b0_0000_0000_0010,
		S_LIM_B  = 13'b0_0000_0000_0100,
		S_LIM_C  = 13'b0_0000_0000_1000,
		S_LIM_D  = 13'b0_0000_0001_0000,
		S_SUM    = 13'b0_0000_0010_0000,
		S_TERM_A = 13'b0_0000_0100_0000,
		S_TERM_B = 13'b0_0000_1000_0000,
		S_TERM_C = 13'b0_0001_0000_0000,
		S_PROD_A = 13'b0_0010_0000_0000,
		S_PROD_B = 13'b0_0100_0000_0000,
		S_PROD_C = 13'b0_1000_0000_0000,
		S_DONE   = 13'b1_0000_0000_0000
	} state_t;

	state_t state_q;

	// Controller state.
	logic [30:0] last_sum_q;
	logic [30:0] last_drive_q;
	logic [30:0] sum_limit_q;

	// Working registers of the current request.
	logic signed [31:0] err_q;
	logic        inh_q;
	logic        frozen_q;
	logic        clamp_q;
	logic        noupd_q;
	logic [62:0] num_q;
	logic [30:0] newsum_q;
	logic [40:0] inner_q;
	logic [39:0] lo_q;
	logic [30:0] drive_q;

	// Zero settings act as one.
	logic [15:0] g_eff;
	logic [23:0] r_eff;
	logic [15:0] dt_eff;
	assign g_eff = (cfg.gain_q8_8 == 16'd0) ? 16'd1 : cfg.gain_q8_8;
	assign r_eff = (cfg.reset_time_ms == 24'd0) ? 24'd1 : cfg.reset_time_ms;
	assign dt_eff = (cfg.interval_ms == 16'd0) ? 16'd1 : cfg.interval_ms;

	// Shared multiplier operand selection.
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_q;
	always_comb begin
		case (state_q)
			S_LIM_A: begin
				mul_a = {1'b0, cfg.max_output};
				mul_b = {8'b0, r_eff};
			end
			S_LIM_B: begin
				mul_a = {16'b0, g_eff};
				mul_b = {16'b0, dt_eff};
			end
			S_TERM_A: begin
				mul_a = {1'b0, newsum_q};
				mul_b = {16'b0, dt_eff};
			end
			S_PROD_A: begin
				mul_a = {16'b0, g_eff};
				mul_b = {8'b0, inner_q[23:0]};
			end
			S_PROD_B: begin
				mul_a = {16'b0, g_eff};
				mul_b = {15'b0, inner_q[40:24]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pca_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_q)
	);

	// Divider: limit division first, integral term division later.
	logic        div_start;
	logic [63:0] div_num;
	logic [31:0] div_den;
	logic        div_done;
	logic [63:0] div_quot;
	assign div_start = (state_q == S_LIM_C) || (state_q == S_TERM_B);
	assign div_num = (state_q == S_LIM_C) ? {1'b0, num_q} : mul_q;
	assign div_den = (state_q == S_LIM_C) ? mul_q[31:0] : {8'b0, r_eff};

	pca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done_q (div_done),
		.quot   (div_quot)
	);

	// Integral sum step: add the error, floor at zero, clamp to the limit.
	logic signed [32:0] ns;
	logic [30:0] ns_sel;
	logic        ns_clamp;
	assign ns = $signed({2'b0, last_sum_q}) + $signed({err_q[31], err_q});
	always_comb begin
		ns_clamp = 1'b0;
		if (ns[32]) begin
			ns_sel = '0;
		end else if (ns[31:0] > {1'b0, sum_limit_q}) begin
			ns_sel = sum_limit_q;
			ns_clamp = 1'b1;
		end else begin
			ns_sel = ns[30:0];
		end
	end

	// Inner term: error plus the integral term, capped at 2^40.
	logic signed [48:0] inner_w;
	logic        inner_le0;
	logic [40:0] inner_cap;
	assign inner_w = $signed({{17{err_q[31]}}, err_q}) + $signed({2'b0, div_quot[46:0]});
	assign inner_le0 = inner_w[48] || (inner_w == 49'sd0);
	assign inner_cap = (inner_w > $signed(INNER_CAP)) ? INNER_CAP[40:0] : inner_w[40:0];

	// Gain product: assemble both partial products and drop the Q8.8 fraction.
	logic [56:0] prod_full;
	logic [48:0] prod;
	logic        prod_over;
	assign prod_full = {17'b0, lo_q} + {mul_q[32:0], 24'b0};
	assign prod = prod_full[56:8];
	assign prod_over = prod > {18'b0, cfg.max_output};

	// Saturated limit quotient.
	logic [30:0] lim_sat;
	assign lim_sat = (|div_quot[63:31]) ? SAT31 : div_quot[30:0];

	// Result of the current request.
	logic upd;
	assign upd = !frozen_q && !inh_q && !noupd_q;
	assign res.drive_out = frozen_q ? last_drive_q : drive_q;
	assign res.integral_sum = upd ? newsum_q : last_sum_q;
	assign res.inhibited = frozen_q | clamp_q | inh_q | noupd_q;
	assign res_valid = (state_q == S_DONE);
	assign ready = (state_q == S_IDLE);

	// Sequencer and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_sum_q <= '0;
			last_drive_q <= '0;
			sum_limit_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (item.reset_pulse) begin
							last_sum_q <= '0;
							last_drive_q <= '0;
							sum_limit_q <= '0;
						end
						if (item.freeze_req || !item.inputs_valid) begin
							state_q <= S_DONE;
						end else if (item.reset_pulse || sum_limit_q == '0) begin
							state_q <= S_LIM_A;
						end else begin
							state_q <= S_SUM;
						end
					end
				end
				S_LIM_A:  state_q <= S_LIM_B;
				S_LIM_B:  state_q <= S_LIM_C;
				S_LIM_C:  state_q <= S_LIM_D;
				S_LIM_D: begin
					if (div_done) begin
						sum_limit_q <= lim_sat;
						state_q <= S_SUM;
					end
				end
				S_SUM:    state_q <= S_TERM_A;
				S_TERM_A: state_q <= S_TERM_B;
				S_TERM_B: state_q <= S_TERM_C;
				S_TERM_C: begin
					if (div_done) begin
						state_q <= inner_le0 ? S_DONE : S_PROD_A;
					end
				end
				S_PROD_A: state_q <= S_PROD_B;
				S_PROD_B: state_q <= S_PROD_C;
				S_PROD_C: state_q <= S_DONE;
				S_DONE: begin
					if (res_ready) begin
						if (!frozen_q) begin
							last_sum_q <= res.integral_sum;
							last_drive_q <= res.drive_out;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				err_q <= item.error_in;
				inh_q <= item.inhibit_req;
				frozen_q <= item.freeze_req || !item.inputs_valid;
				clamp_q <= 1'b0;
				noupd_q <= 1'b0;
			end
			S_LIM_B: num_q <= {mul_q[54:0], 8'b0};
			S_SUM: begin
				newsum_q <= ns_sel;
				clamp_q <= ns_clamp;
			end
			S_TERM_C: begin
				inner_q <= inner_cap;
				if (inner_le0) begin
					drive_q <= '0;
				end
			end
			S_PROD_B: lo_q <= mul_q[39:0];
			S_PROD_C: begin
				drive_q <= prod_over ? cfg.max_output : prod[30:0];
				noupd_q <= prod_over;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/pi_controller_antiwindup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller with anti-windup
// Top level: configuration registers, request intake and output register
// around the sequenced controller core.
// ----------------------------------------------------------------------------
// One request at a time: a frozen or invalid request goes straight from
// acceptance to its result. A normal request uses the single shared
// 64-step divider once for the integral term, and once more for the limit
// when the integral limit must be recomputed (first request, after a reset
// pulse, or while the limit is zero). in_stall stays high until the result
// has moved to the output register; the next request may then be accepted
// while the result waits.
module pi_controller_antiwindup import pca_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  error_in,
	input  logic                reset_pulse,
	input  logic                freeze_req,
	input  logic                inhibit_req,
	input  logic                inputs_valid,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [30:0]         drive_out,
	output logic [30:0]         integral_sum,
	output logic                inhibited
);

	cfg_t    cfg_q;
	item_t   item;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    core_ready;
	logic    res_valid;
	logic    res_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_q8_8 <= GAIN_RST;
			cfg_q.reset_time_ms <= RESET_TIME_RST;
			cfg_q.max_output <= MAX_OUTPUT_RST;
			cfg_q.interval_ms <= INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GAIN:       cfg_q.gain_q8_8 <= cfg_wdata[15:0];
				REG_RESET_TIME: cfg_q.reset_time_ms <= cfg_wdata[23:0];
				REG_MAX_OUTPUT: cfg_q.max_output <= cfg_wdata[30:0];
				REG_INTERVAL:   cfg_q.interval_ms <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Request intake.
	assign item.error_in = error_in;
	assign item.reset_pulse = reset_pulse;
	assign item.freeze_req = freeze_req;
	assign item.inhibit_req = inhibit_req;
	assign item.inputs_valid = inputs_valid;
	assign in_stall = !core_ready;

	pca_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (in_valid && core_ready),
		.item       (item),
		.ready      (core_ready),
		.res_valid  (res_valid),
		.res_ready  (res_take),
		.res        (res)
	);

	// Output register: loads when empty or being drained.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_out = res_q.drive_out;
	assign integral_sum = res_q.integral_sum;
	assign inhibited = res_q.inhibited;

endmodule

>>> hw/rtl/pca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller port checker
// Checks the port behavior of the PI controller over time, bound to the top
// level.
// ----------------------------------------------------------------------------
module pca_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic signed [31:0]  error_in,
	input logic                reset_pulse,
	input logic                freeze_req,
	input logic                inhibit_req,
	input logic                inputs_valid,
	input logic                out_valid,
	input logic                out_stall,
	input logic [30:0]         drive_out,
	input logic [30:0]         integral_sum,
	input logic                inhibited
);

	// A stalled request stays offered with the same payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=>
		(in_valid && $stable(error_in) && $stable(reset_pulse) && $stable(freeze_req) &&
		$stable(inhibit_req) && $stable(inputs_valid)))
		else $error("stalled request changed");

	// An accepted request keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted request");

	// A new result only appears after the block was busy.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in progress");

	// A stalled result stays valid.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	// A stalled result keeps its payload.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		($stable(drive_out) && $stable(integral_sum) && $stable(inhibited)))
		else $error("stalled result changed");

endmodule

bind pi_controller_antiwindup pca_checker u_pca_checker (.*);

>>> verif/pi_controller_antiwindup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI controller with anti-windup: self-checking testbench
// Feeds error samples and control flags through the valid/stall request
// channel under several register settings and idle patterns. A built-in
// fixed-point predictor computes each expected output, integral sum and
// inhibited flag, and a monitor compares them with the block's results.
// ----------------------------------------------------------------------------
module pi_controller_antiwindup_tb;
	import pca_pkg::*;

	localparam int WDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 150;
	localparam longint INNER_MAX = 64'sh100_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] error_in = '0;
	logic               reset_pulse = 1'b0;
	logic               freeze_req = 1'b0;
	logic               inhibit_req = 1'b0;
	logic               inputs_valid = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [30:0]        drive_out;
	logic [30:0]        integral_sum;
	logic               inhibited;

	// Requests waiting to be offered and controller outputs waiting to arrive.
	item_t   pending_requests[$];
	result_t pending_outputs[$];

	// Predictor copy of the registers and the controller state.
	logic [15:0] mdl_gain = GAIN_RST;
	logic [23:0] mdl_rtime = RESET_TIME_RST;
	logic [30:0] mdl_max = MAX_OUTPUT_RST;
	logic [15:0] mdl_dt = INTERVAL_RST;
	logic [31:0] st_sum = '0;
	logic [31:0] st_drive = '0;
	logic [31:0] st_limit = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_token = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;
	int n_req = 0;
	int n_res = 0;
	int n_err = 0;
	int n_phase = 0;

	pi_controller_antiwindup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.error_in     (error_in),
		.reset_pulse  (reset_pulse),
		.freeze_req   (freeze_req),
		.inhibit_req  (inhibit_req),
		.inputs_valid (inputs_valid),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_out    (drive_out),
		.integral_sum (integral_sum),
		.inhibited    (inhibited)
	);

	always #6 clk = ~clk;

	// One controller tick: updates the predicted state and returns the outputs.
	function automatic result_t pi_step_predict(input item_t it);
		logic [63:0] g, r, dt, q, term, prod;
		longint err, ns, inner, lim_s;
		logic [31:0] nsum, drv, sm;
		logic inh_flag, out_clamped;
		result_t res;
		g = (mdl_gain == '0) ? 64'd1 : {48'd0, mdl_gain};
		r = (mdl_rtime == '0) ? 64'd1 : {40'd0, mdl_rtime};
		dt = (mdl_dt == '0) ? 64'd1 : {48'd0, mdl_dt};
		err = {{32{it.error_in[31]}}, it.error_in};
		inh_flag = 1'b0;
		out_clamped = 1'b0;
		if (it.reset_pulse) begin
			st_sum = '0;
			st_drive = '0;
			st_limit = '0;
		end
		drv = st_drive;
		sm = st_sum;
		if (it.freeze_req || !it.inputs_valid) begin
			inh_flag = 1'b1;
		end else begin
			// The integral limit is recomputed whenever the stored one is zero.
			if (st_limit == '0) begin
				q = ({33'd0, mdl_max} * r * 64'd256) / (g * dt);
				st_limit = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
			end
			ns = longint'({32'd0, st_sum}) + err;
			lim_s = longint'({32'd0, st_limit});
			if (ns < 0)
				ns = 0;
			if (ns > lim_s) begin
				ns = lim_s;
				inh_flag = 1'b1;
			end
			nsum = ns[31:0];
			term = ({32'd0, nsum} * dt) / r;
			inner = err + longint'(term);
			if (inner > INNER_MAX)
				inner = INNER_MAX;
			if (inner <= 0) begin
				drv = '0;
			end else begin
				prod = (g * 64'(inner)) >> 8;
				if (prod > {33'd0, mdl_max}) begin
					drv = {1'b0, mdl_max};
					out_clamped = 1'b1;
				end else begin
					drv = prod[31:0];
				end
			end
			// The sum only moves when neither inhibited nor clamped at the output.
			if (!it.inhibit_req && !out_clamped)
				sm = nsum;
			else
				inh_flag = 1'b1;
			st_sum = sm;
			st_drive = drv;
		end
		res.drive_out = drv[30:0];
		res.integral_sum = sm[30:0];
		res.inhibited = inh_flag;
		return res;
	endfunction

	function automatic item_t make_req(input logic [31:0] err, input logic rst,
			input logic frz, input logic inh, input logic vld);
		item_t it;
		it.error_in = err;
		it.reset_pulse = rst;
		it.freeze_req = frz;
		it.inhibit_req = inh;
		it.inputs_valid = vld;
		return it;
	endfunction

	// Error magnitudes spread over many octaves, with some full-range values.
	function automatic logic [31:0] rand_error();
		logic [31:0] mag;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		mag = $urandom >> $urandom_range(4, 31);
		if (pick == 0)
			return $urandom;
		if (pick == 1) begin
			case ($urandom_range(0, 4))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				3: return 32'h0000_0001;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (pick < 4)
			return -mag;
		return mag;
	endfunction

	// Mostly ordinary ticks; some reset pulses, freezes, inhibits and bad inputs.
	function automatic item_t rand_req();
		return make_req(rand_error(), $urandom_range(0, 99) < 5,
			$urandom_range(0, 99) < 7, $urandom_range(0, 99) < 10,
			$urandom_range(0, 99) >= 6);
	endfunction

	function automatic int field_mismatch(input string name, input logic [30:0] exp_v,
			input logic [30:0] act_v);
		if (exp_v === act_v)
			return 0;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		return 1;
	endfunction

	// Request driver: predicts each accepted request and offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				pending_outputs.push_back(pi_step_predict(make_req(error_in, reset_pulse,
					freeze_req, inhibit_req, inputs_valid)));
				n_req++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					item_t nxt;
					nxt = pending_requests.pop_front();
					error_in <= nxt.error_in;
					reset_pulse <= nxt.reset_pulse;
					freeze_req <= nxt.freeze_req;
					inhibit_req <= nxt.inhibit_req;
					inputs_valid <= nxt.inputs_valid;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall, including the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_res++;
				if (pending_outputs.size() == 0) begin
					$display("%0t: unexpected result, expected none, got drive %0d sum %0d inh %0b",
						$time, drive_out, integral_sum, inhibited);
					n_err++;
				end else begin
					result_t want;
					want = pending_outputs.pop_front();
					n_err += field_mismatch("drive_out", want.drive_out, drive_out);
					n_err += field_mismatch("integral_sum", want.integral_sum, integral_sum);
					n_err += field_mismatch("inhibited", {30'd0, want.inhibited},
						{30'd0, inhibited});
				end
			end
			if (hold_token != hold_seen) begin
				hold_seen <= hold_token;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(0, 99) < recv_stall_pct;
			end
		end
	end

	// Watchdog on cycles with no request or result accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
				$display("pi_controller_antiwindup_tb: errors");
				$finish;
			end
		end
	end

	// Waits until every request was accepted and every result has arrived.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || pending_outputs.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes all four registers; only called while the block is idle.
	task automatic set_config(input logic [15:0] g, input logic [23:0] rt,
			input logic [30:0] mx, input logic [15:0] dt);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_GAIN;
		cfg_wdata <= {15'd0, g};
		@(posedge clk);
		cfg_idx <= REG_RESET_TIME;
		cfg_wdata <= {7'd0, rt};
		@(posedge clk);
		cfg_idx <= REG_MAX_OUTPUT;
		cfg_wdata <= mx;
		@(posedge clk);
		cfg_idx <= REG_INTERVAL;
		cfg_wdata <= {15'd0, dt};
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_gain = g;
		mdl_rtime = rt;
		mdl_max = mx;
		mdl_dt = dt;
	endtask

	// A reset pulse first so that the limit follows the new registers.
	task automatic run_phase(input int n, input int send_pct, input int recv_pct,
			input logic hold_off);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		pending_requests.push_back(make_req(rand_error(), 1'b1, 1'b0, 1'b0, 1'b1));
		for (int i = 1; i < n; i++)
			pending_requests.push_back(rand_req());
		if (hold_off) begin
			@(posedge clk);
			hold_token <= ~hold_token;
		end
		wait_drained();
		n_phase++;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests at the reset register values.
		pending_requests.push_back(make_req(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0010_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0008_0000, 1'b0, 1'b0, 1'b1, 1'b1));
		pending_requests.push_back(make_req(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0004_0000, 1'b0, 1'b0, 1'b0, 1'b0));
		pending_requests.push_back(make_req(32'h0030_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0030_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'hFFE0_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0010_0000, 1'b1, 1'b1, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0001_0000, 1'b1, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0020_0000, 1'b1, 1'b0, 1'b1, 1'b1));
		pending_requests.push_back(make_req(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0));
		pending_requests.push_back(make_req(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1));
		pending_requests.push_back(make_req(32'h4000_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		pending_requests.push_back(make_req(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1));
		wait_drained();

		// Random phases over extreme and typical register settings.
		run_phase(75, 0, 0, 1'b0);
		set_config(16'd1, 24'd16777215, 31'h7FFF_FFFF, 16'd65535);
		run_phase(75, 80, 0, 1'b0);
		set_config(16'd65535, 24'd1, 31'd0, 16'd1);
		run_phase(75, 0, 80, 1'b0);
		set_config(16'd384, 24'd500, 31'd3276800, 16'd100);
		run_phase(75, 7, 7, 1'b0);
		set_config(16'($urandom_range(64, 1024)), 24'($urandom_range(1, 5000)),
			31'($urandom >> $urandom_range(1, 16)), 16'($urandom_range(1, 2000)));
		run_phase(75, 0, 0, 1'b1);
		set_config(16'd65535, 24'd16777215, 31'h7FFF_FFFF, 16'd65535);
		run_phase(40, 7, 7, 1'b0);
		set_config(16'd256, 24'd1000, 31'd6553600, 16'd1000);
		run_phase(40, 80, 80, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_outputs.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, pending_outputs.size());
		$display("Covered %0d requests and %0d results over %0d random phases,", n_req, n_res,
			n_phase);
		$display("with extreme register settings, idle patterns and a long output hold-off.");
		if (n_err == 0 && pending_outputs.size() == 0)
			$display("pi_controller_antiwindup_tb: clean");
		else
			$display("pi_controller_antiwindup_tb: errors");
		$finish;
	end

endmodule
